// File: rtl/bilinear_quad_map_and_gradient_defines.svh
// assertion macros used by the checker file
`ifndef BILINEAR_QUAD_MAP_AND_GRADIENT_DEFINES_SVH
`define BILINEAR_QUAD_MAP_AND_GRADIENT_DEFINES_SVH

// same-cycle implication, off during reset
`define BQM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BQM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always on
`define BQM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bqm_pkg.sv
// shared types and constants of the bilinear quad map block
package bqm_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    // quotient bits of the gradient divider: 16 integer plus 17 fraction
    localparam int DIV_STEPS = 33;
    // low numerator bits fed into the divider one per step
    localparam int DIV_LOW_BITS = 16;

    typedef enum logic [2:0] {
        CFG_X0 = 3'd0,
        CFG_Y0 = 3'd1,
        CFG_X1 = 3'd2,
        CFG_Y1 = 3'd3,
        CFG_X2 = 3'd4,
        CFG_Y2 = 3'd5,
        CFG_X3 = 3'd6,
        CFG_Y3 = 3'd7
    } t_cfg_idx;

    // word handed from the front to the divider back end
    typedef struct packed {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic        [31:0] weight;
        logic        [31:0] value;
        logic        [63:0] anx;
        logic        [63:0] any;
        logic        [63:0] adet;
        logic               negx;
        logic               negy;
        logic               satx;
        logic               saty;
        logic               sing;
    } t_mid;

    typedef struct packed {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic        [31:0] weight;
        logic        [31:0] value;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic               sing;
    } t_res;

endpackage

// File: rtl/bqm_front.sv
// front pipeline: configuration, map, jacobian, determinant, weight, classification
module bqm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic signed [17:0]    i_ref_xi,
    input  logic signed [17:0]    i_ref_eta,
    input  logic [31:0]           i_ref_weight,
    input  logic signed [31:0]    i_ref_value,
    input  logic signed [31:0]    i_ref_dxi,
    input  logic signed [31:0]    i_ref_deta,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output bqm_pkg::t_mid         o_q_word
);
    import bqm_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        priority if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // (lin*2^16 + bil) / 2^18, nearest with ties up, clamped
    function automatic logic signed [31:0] jac(input logic signed [33:0] lin,
                                               input logic signed [51:0] bil);
        logic signed [53:0] s;
        s = (54'(lin) <<< 16) + 54'(bil) + 54'sd131072;
        return sat32(40'(s >>> 18));
    endfunction

    logic signed [31:0] r_vx0, r_vy0, r_vx1, r_vy1, r_vx2, r_vy2, r_vx3, r_vy3;
    logic signed [33:0] r_xc0, r_xc1, r_xc2, r_xc3, r_yc0, r_yc1, r_yc2, r_yc3;
    logic [7:0]         r_fv;
    logic               adv;

    logic signed [17:0] r_s0_xi, r_s0_eta;
    logic        [31:0] r_s0_w, r_s0_val;
    logic signed [31:0] r_s0_dxi, r_s0_deta;

    logic signed [35:0] r_s1_p;
    logic signed [51:0] r_s1_c1x, r_s1_c2x, r_s1_c1y, r_s1_c2y;
    logic signed [51:0] r_s1_bxe, r_s1_bxx, r_s1_bye, r_s1_byx;
    logic        [31:0] r_s1_w, r_s1_val;
    logic signed [31:0] r_s1_dxi, r_s1_deta;

    logic signed [53:0] r_s2_cxph, r_s2_cyph;
    logic signed [49:0] r_s2_cxpl, r_s2_cypl;
    logic signed [54:0] r_s2_ax, r_s2_ay;
    logic signed [31:0] r_s2_j11, r_s2_j12, r_s2_j21, r_s2_j22;
    logic        [31:0] r_s2_w, r_s2_val;
    logic signed [31:0] r_s2_dxi, r_s2_deta;
    logic signed [19:0] ph;
    logic        [15:0] pl;

    logic signed [31:0] r_s3_mx, r_s3_my;
    logic signed [63:0] r_s3_d1, r_s3_d2, r_s3_nx1, r_s3_nx2, r_s3_ny1, r_s3_ny2;
    logic        [31:0] r_s3_w, r_s3_val;
    logic signed [34:0] lox, loy;
    logic signed [56:0] totx, toty;

    logic signed [31:0] r_s4_mx, r_s4_my;
    logic signed [63:0] r_s4_det, r_s4_nx, r_s4_ny;
    logic        [31:0] r_s4_w, r_s4_val;

    logic signed [31:0] r_s5_mx, r_s5_my;
    logic        [63:0] r_s5_adet, r_s5_anx, r_s5_any;
    logic               r_s5_negx, r_s5_negy, r_s5_sing;
    logic        [31:0] r_s5_w, r_s5_val;

    logic signed [31:0] r_s6_mx, r_s6_my;
    logic        [63:0] r_s6_whi, r_s6_wlo, r_s6_adet, r_s6_anx, r_s6_any;
    logic               r_s6_negx, r_s6_negy, r_s6_sing, r_s6_satx, r_s6_saty;
    logic        [31:0] r_s6_val;
    logic        [64:0] wsum;

    t_mid               r_s7;

    // the whole front moves together unless its last word cannot leave
    assign adv      = !r_fv[7] || !i_q_full;
    assign o_full   = !adv;
    assign o_q_push = r_fv[7] && !i_q_full;
    assign o_q_word = r_s7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx0 <= 32'sd0;     r_vy0 <= 32'sd0;
            r_vx1 <= 32'sd65536; r_vy1 <= 32'sd0;
            r_vx2 <= 32'sd65536; r_vy2 <= 32'sd65536;
            r_vx3 <= 32'sd0;     r_vy3 <= 32'sd65536;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_X0: r_vx0 <= i_cfg_data;
                CFG_Y0: r_vy0 <= i_cfg_data;
                CFG_X1: r_vx1 <= i_cfg_data;
                CFG_Y1: r_vy1 <= i_cfg_data;
                CFG_X2: r_vx2 <= i_cfg_data;
                CFG_Y2: r_vy2 <= i_cfg_data;
                CFG_X3: r_vx3 <= i_cfg_data;
                CFG_Y3: r_vy3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coefficients are kept at four times their value, exact
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xc0 <= 34'sd131072; r_xc1 <= 34'sd131072; r_xc2 <= 34'sd0;
            r_xc3 <= 34'sd0;
            r_yc0 <= 34'sd131072; r_yc1 <= 34'sd0; r_yc2 <= 34'sd131072;
            r_yc3 <= 34'sd0;
        end else begin
            r_xc0 <= 34'(r_vx0) + 34'(r_vx1) + 34'(r_vx2) + 34'(r_vx3);
            r_xc1 <= 34'(r_vx1) + 34'(r_vx2) - 34'(r_vx0) - 34'(r_vx3);
            r_xc2 <= 34'(r_vx2) + 34'(r_vx3) - 34'(r_vx0) - 34'(r_vx1);
            r_xc3 <= 34'(r_vx0) + 34'(r_vx2) - 34'(r_vx1) - 34'(r_vx3);
            r_yc0 <= 34'(r_vy0) + 34'(r_vy1) + 34'(r_vy2) + 34'(r_vy3);
            r_yc1 <= 34'(r_vy1) + 34'(r_vy2) - 34'(r_vy0) - 34'(r_vy3);
            r_yc2 <= 34'(r_vy2) + 34'(r_vy3) - 34'(r_vy0) - 34'(r_vy1);
            r_yc3 <= 34'(r_vy0) + 34'(r_vy2) - 34'(r_vy1) - 34'(r_vy3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (adv) begin
            r_fv <= {r_fv[6:0], i_push};
        end
    end

    always_comb begin
        ph   = 20'(r_s1_p >>> 16);
        pl   = r_s1_p[15:0];
        lox  = 35'((51'(r_s2_cxpl) + 51'sd8589934592) >>> 16);
        loy  = 35'((51'(r_s2_cypl) + 51'sd8589934592) >>> 16);
        totx = 57'(r_s2_ax) + 57'(r_s2_cxph) + 57'(lox);
        toty = 57'(r_s2_ay) + 57'(r_s2_cyph) + 57'(loy);
        wsum = 65'(r_s6_whi) + 65'((65'(r_s6_wlo) + 65'd2147483648) >> 32);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_xi   <= i_ref_xi;
            r_s0_eta  <= i_ref_eta;
            r_s0_w    <= i_ref_weight;
            r_s0_val  <= i_ref_value;
            r_s0_dxi  <= i_ref_dxi;
            r_s0_deta <= i_ref_deta;

            r_s1_p    <= 36'(r_s0_xi) * 36'(r_s0_eta);
            r_s1_c1x  <= 52'(r_xc1) * 52'(r_s0_xi);
            r_s1_c2x  <= 52'(r_xc2) * 52'(r_s0_eta);
            r_s1_c1y  <= 52'(r_yc1) * 52'(r_s0_xi);
            r_s1_c2y  <= 52'(r_yc2) * 52'(r_s0_eta);
            r_s1_bxe  <= 52'(r_xc3) * 52'(r_s0_eta);
            r_s1_bxx  <= 52'(r_xc3) * 52'(r_s0_xi);
            r_s1_bye  <= 52'(r_yc3) * 52'(r_s0_eta);
            r_s1_byx  <= 52'(r_yc3) * 52'(r_s0_xi);
            r_s1_w    <= r_s0_w;
            r_s1_val  <= r_s0_val;
            r_s1_dxi  <= r_s0_dxi;
            r_s1_deta <= r_s0_deta;

            // xi*eta split into a high part and a 16 bit low part
            r_s2_cxph <= 54'(r_xc3) * 54'(ph);
            r_s2_cyph <= 54'(r_yc3) * 54'(ph);
            r_s2_cxpl <= 50'(r_xc3) * 50'($signed({1'b0, pl}));
            r_s2_cypl <= 50'(r_yc3) * 50'($signed({1'b0, pl}));
            r_s2_ax   <= (55'(r_xc0) <<< 16) + 55'(r_s1_c1x) + 55'(r_s1_c2x);
            r_s2_ay   <= (55'(r_yc0) <<< 16) + 55'(r_s1_c1y) + 55'(r_s1_c2y);
            r_s2_j11  <= jac(r_xc1, r_s1_bxe);
            r_s2_j12  <= jac(r_xc2, r_s1_bxx);
            r_s2_j21  <= jac(r_yc1, r_s1_bye);
            r_s2_j22  <= jac(r_yc2, r_s1_byx);
            r_s2_w    <= r_s1_w;
            r_s2_val  <= r_s1_val;
            r_s2_dxi  <= r_s1_dxi;
            r_s2_deta <= r_s1_deta;

            r_s3_mx   <= sat32(40'(totx >>> 18));
            r_s3_my   <= sat32(40'(toty >>> 18));
            r_s3_d1   <= 64'(r_s2_j11) * 64'(r_s2_j22);
            r_s3_d2   <= 64'(r_s2_j12) * 64'(r_s2_j21);
            r_s3_nx1  <= 64'(r_s2_j22) * 64'(r_s2_dxi);
            r_s3_nx2  <= 64'(r_s2_j21) * 64'(r_s2_deta);
            r_s3_ny1  <= 64'(r_s2_j11) * 64'(r_s2_deta);
            r_s3_ny2  <= 64'(r_s2_j12) * 64'(r_s2_dxi);
            r_s3_w    <= r_s2_w;
            r_s3_val  <= r_s2_val;

            r_s4_mx   <= r_s3_mx;
            r_s4_my   <= r_s3_my;
            r_s4_det  <= r_s3_d1 - r_s3_d2;
            r_s4_nx   <= r_s3_nx1 - r_s3_nx2;
            r_s4_ny   <= r_s3_ny1 - r_s3_ny2;
            r_s4_w    <= r_s3_w;
            r_s4_val  <= r_s3_val;

            // sign and magnitude split ahead of the divider
            r_s5_mx   <= r_s4_mx;
            r_s5_my   <= r_s4_my;
            r_s5_adet <= r_s4_det[63] ? (~r_s4_det + 64'd1) : r_s4_det;
            r_s5_anx  <= r_s4_nx[63] ? (~r_s4_nx + 64'd1) : r_s4_nx;
            r_s5_any  <= r_s4_ny[63] ? (~r_s4_ny + 64'd1) : r_s4_ny;
            r_s5_negx <= r_s4_nx[63] ^ r_s4_det[63];
            r_s5_negy <= r_s4_ny[63] ^ r_s4_det[63];
            r_s5_sing <= (r_s4_det == 64'sd0);
            r_s5_w    <= r_s4_w;
            r_s5_val  <= r_s4_val;

            r_s6_mx   <= r_s5_mx;
            r_s6_my   <= r_s5_my;
            r_s6_whi  <= 64'(r_s5_w) * 64'(r_s5_adet[63:32]);
            r_s6_wlo  <= 64'(r_s5_w) * 64'(r_s5_adet[31:0]);
            r_s6_adet <= r_s5_adet;
            r_s6_anx  <= r_s5_anx;
            r_s6_any  <= r_s5_any;
            r_s6_negx <= r_s5_negx;
            r_s6_negy <= r_s5_negy;
            r_s6_sing <= r_s5_sing;
            // quotient of 2^16 or more saturates
            r_s6_satx <= ({16'b0, r_s5_anx[63:16]} >= r_s5_adet);
            r_s6_saty <= ({16'b0, r_s5_any[63:16]} >= r_s5_adet);
            r_s6_val  <= r_s5_val;

            r_s7.mx     <= r_s6_mx;
            r_s7.my     <= r_s6_my;
            r_s7.weight <= (wsum > 65'h0_ffff_ffff) ? 32'hffff_ffff : wsum[31:0];
            r_s7.value  <= r_s6_val;
            r_s7.anx    <= r_s6_anx;
            r_s7.any    <= r_s6_any;
            r_s7.adet   <= r_s6_adet;
            r_s7.negx   <= r_s6_negx;
            r_s7.negy   <= r_s6_negy;
            r_s7.satx   <= r_s6_satx;
            r_s7.saty   <= r_s6_saty;
            r_s7.sing   <= r_s6_sing;
        end
    end

endmodule

// File: rtl/bqm_queue.sv
// short word queue between the front and the divider back end
module bqm_queue #(
    parameter int DEPTH = bqm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bqm_pkg::t_mid   i_word,
    output logic            o_full,
    input  logic            i_pop,
    output bqm_pkg::t_mid   o_word,
    output logic            o_empty
);
    import bqm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_mid          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: rtl/bqm_back.sv
// back end: two bit-per-stage restoring dividers and the result register
module bqm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bqm_pkg::t_mid   i_q_word,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output bqm_pkg::t_res   o_res
);
    import bqm_pkg::*;

    typedef struct packed {
        t_mid                   w;
        logic [63:0]            rx;
        logic [63:0]            ry;
        logic [DIV_STEPS-1:0]   qx;
        logic [DIV_STEPS-1:0]   qy;
    } t_dstage;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [64:0] dstep(input logic [63:0] r, input logic nb,
                                          input logic [63:0] b);
        logic [64:0] t;
        logic [64:0] res;
        t = {r, nb};
        if (t >= {1'b0, b}) begin
            res = {1'b1, 64'(t - {1'b0, b})};
        end else begin
            res = {1'b0, t[63:0]};
        end
        return res;
    endfunction

    // round the 17 bit fraction, apply sign, clamp
    function automatic logic signed [31:0] grad(input logic [DIV_STEPS-1:0] q,
                                                input logic neg, input logic sat,
                                                input logic sing);
        logic [DIV_STEPS:0]  mr;
        logic signed [31:0]  g;
        mr = (($bits(mr))'(q) + ($bits(mr))'(1)) >> 1;
        priority if (sing) begin
            g = 32'sd0;
        end else if (sat) begin
            g = neg ? 32'sh80000000 : 32'sh7fffffff;
        end else if (neg) begin
            g = (mr > ($bits(mr))'(64'd2147483648)) ? 32'sh80000000
                                                     : 32'(~mr + ($bits(mr))'(1));
        end else begin
            g = (mr > ($bits(mr))'(64'd2147483647)) ? 32'sh7fffffff : 32'(mr);
        end
        return g;
    endfunction

    logic [DIV_STEPS-1:0] r_dv;
    t_dstage              r_dw [DIV_STEPS];
    logic                 r_ov;
    t_res                 r_o;
    logic                 adv;
    t_dstage              last;

    // all stages move together unless the result register is held
    assign adv     = !r_ov || i_pop;
    assign o_empty = !r_ov;
    assign o_q_pop = adv && !i_q_empty;
    assign o_res   = r_o;
    assign last    = r_dw[DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        t_dstage     src;
        logic        src_v;
        logic        nbx, nby;
        logic [64:0] sx, sy;

        if (k == 0) begin : g_first
            always_comb begin
                src_v   = o_q_pop;
                src.w   = i_q_word;
                src.rx  = {16'b0, i_q_word.anx[63:16]};
                src.ry  = {16'b0, i_q_word.any[63:16]};
                src.qx  = '0;
                src.qy  = '0;
            end
        end else begin : g_next
            always_comb begin
                src_v = r_dv[k-1];
                src   = r_dw[k-1];
            end
        end

        // low numerator bits first, then zeros for the fraction
        if (k < DIV_LOW_BITS) begin : g_low
            assign nbx = src.w.anx[DIV_LOW_BITS-1-k];
            assign nby = src.w.any[DIV_LOW_BITS-1-k];
        end else begin : g_zero
            assign nbx = 1'b0;
            assign nby = 1'b0;
        end

        assign sx = dstep(src.rx, nbx, src.w.adet);
        assign sy = dstep(src.ry, nby, src.w.adet);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (adv) begin
                r_dv[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dw[k].w  <= src.w;
                r_dw[k].rx <= sx[63:0];
                r_dw[k].ry <= sy[63:0];
                r_dw[k].qx <= {src.qx[DIV_STEPS-2:0], sx[64]};
                r_dw[k].qy <= {src.qy[DIV_STEPS-2:0], sy[64]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_dv[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o.mx     <= last.w.mx;
            r_o.my     <= last.w.my;
            r_o.weight <= last.w.weight;
            r_o.value  <= last.w.value;
            r_o.gx     <= grad(last.qx, last.w.negx, last.w.satx, last.w.sing);
            r_o.gy     <= grad(last.qy, last.w.negy, last.w.saty, last.w.sing);
            r_o.sing   <= last.w.sing;
        end
    end

endmodule

// File: rtl/bilinear_quad_map_and_gradient.sv
// Bilinear quad map and gradient: takes one word per clock and returns one
// word per clock, sustained while results are popped. A word passes the
// front pipeline (map, jacobian, determinant, weight scaling), the word
// queue and then the back end, where the two gradient quotients are formed
// by restoring dividers that retire one quotient bit per stage over 33 stages,
// followed by a result register. Vertex writes pass through the vertex
// registers into the coefficient registers before they take effect; write
// them only while no word is in flight.
module bilinear_quad_map_and_gradient #(
    parameter int QUEUE_DEPTH = bqm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                push,
    output logic                full,
    input  logic signed [17:0]  i_ref_xi,
    input  logic signed [17:0]  i_ref_eta,
    input  logic [31:0]         i_ref_weight,
    input  logic signed [31:0]  i_ref_value,
    input  logic signed [31:0]  i_ref_dxi,
    input  logic signed [31:0]  i_ref_deta,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  o_mapped_x,
    output logic signed [31:0]  o_mapped_y,
    output logic [31:0]         o_mapped_weight,
    output logic signed [31:0]  o_value_out,
    output logic signed [31:0]  o_grad_x,
    output logic signed [31:0]  o_grad_y,
    output logic                o_singular
);
    import bqm_pkg::*;

    t_mid  f_word, q_word;
    logic  f_push, q_full, q_pop, q_empty;
    t_res  res;

    bqm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_ref_xi    (i_ref_xi),
        .i_ref_eta   (i_ref_eta),
        .i_ref_weight(i_ref_weight),
        .i_ref_value (i_ref_value),
        .i_ref_dxi   (i_ref_dxi),
        .i_ref_deta  (i_ref_deta),
        .i_q_full    (q_full),
        .o_q_push    (f_push),
        .o_q_word    (f_word)
    );

    bqm_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_push),
        .i_word (f_word),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_word (q_word),
        .o_empty(q_empty)
    );

    bqm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_word (q_word),
        .i_q_empty(q_empty),
        .o_q_pop  (q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_res    (res)
    );

    assign o_mapped_x      = res.mx;
    assign o_mapped_y      = res.my;
    assign o_mapped_weight = res.weight;
    assign o_value_out     = res.value;
    assign o_grad_x        = res.gx;
    assign o_grad_y        = res.gy;
    assign o_singular      = res.sing;

endmodule

// File: rtl/bqm_checker.sv
// port-level checks on the bilinear quad map block, bound to the top level
`include "bilinear_quad_map_and_gradient_defines.svh"

module bqm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         push,
    input logic         full,
    input logic         empty,
    input logic         pop,
    input logic [31:0]  o_mapped_weight,
    input logic [31:0]  o_grad_x,
    input logic [31:0]  o_grad_y,
    input logic         o_singular
);

    // singular word carries zero gradients and zero weight
    `BQM_ASSERT_NOW(a_sing_zero, i_clk, i_rst_n, !empty && o_singular, o_grad_x == 32'd0 && o_grad_y == 32'd0 && o_mapped_weight == 32'd0, "singular word with nonzero gradient or weight")

    // a waiting word stays put until taken
    `BQM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_grad_x) && $stable(o_grad_y) && $stable(o_singular), "waiting result word changed")

    // reset leaves nothing to read and room to write
    `BQM_ASSERT_NEXT_ALWAYS(a_reset, i_clk, !i_rst_n, empty && !full, "queue flags wrong after reset")

    // a push can only be blocked by a word that is already somewhere inside
    `BQM_ASSERT_NEXT(a_full_cause, i_clk, i_rst_n, empty && !full && !push, !full, "full raised with nothing pushed")

endmodule

bind bilinear_quad_map_and_gradient bqm_checker u_bqm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_mapped_weight(o_mapped_weight),
    .o_grad_x       (o_grad_x),
    .o_grad_y       (o_grad_y),
    .o_singular     (o_singular)
);
